>>> src/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request stream parser package
// Shared types, event and error codes, and limits for the request parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

  localparam int unsigned MaxHeaders = 64;
  localparam int unsigned OffsetBits = 16;
  localparam int unsigned LengthBits = 32;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_METHOD   = 4'd1,
    EV_URI      = 4'd2,
    EV_VERSION  = 4'd3,
    EV_HEADER   = 4'd4,
    EV_HDR_END  = 4'd5,
    EV_BODY     = 4'd6,
    EV_COMPLETE = 4'd7,
    EV_ERROR    = 4'd8
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_METHOD      = 3'd1,
    ERR_VER_MALFORM = 3'd2,
    ERR_VER_UNKNOWN = 3'd3,
    ERR_HEADERS     = 3'd4,
    ERR_CHUNK       = 3'd5
  } error_e;

  typedef enum logic [1:0] {
    KIND_STREAM  = 2'd0,
    KIND_LENGTH  = 2'd1,
    KIND_CHUNKED = 2'd2
  } kind_e;

  // Configuration register indexes.
  localparam logic [0:0] RegHeaderLimit = 1'b0;

  // Keyword byte for method m at position p (zero where past its end).
  function automatic logic [7:0] kw_char(input logic [3:0] m, input logic [3:0] p);
    logic [8*8-1:0] s;
    logic [3:0]     n;
    s = '0;
    n = 4'd0;
    unique case (m)
      4'd0: begin s = {"GET ", 32'h0};     n = 4'd4; end
      4'd1: begin s = {"POST ", 24'h0};    n = 4'd5; end
      4'd2: begin s = {"PUT ", 32'h0};     n = 4'd4; end
      4'd3: begin s = {"PATCH ", 16'h0};   n = 4'd6; end
      4'd4: begin s = {"HEAD ", 24'h0};    n = 4'd5; end
      4'd5: begin s = {"DELETE ", 8'h0};   n = 4'd7; end
      4'd6: begin s = "CONNECT ";          n = 4'd8; end
      4'd7: begin s = "OPTIONS ";          n = 4'd8; end
      4'd8: begin s = {"TRACE ", 16'h0};   n = 4'd6; end
      default: begin s = '0; n = 4'd0; end
    endcase
    if (p < n) kw_char = s[63 - 8*p[2:0] -: 8];
    else kw_char = 8'h00;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] m);
    unique case (m)
      4'd0, 4'd2: kw_len = 4'd4;
      4'd1, 4'd4: kw_len = 4'd5;
      4'd3, 4'd8: kw_len = 4'd6;
      4'd5:       kw_len = 4'd7;
      4'd6, 4'd7: kw_len = 4'd8;
      default:    kw_len = 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] p);
    logic [17*8-1:0] s;
    s = "transfer-encoding";
    te_char = (p < 5'd17) ? s[135 - 8*p -: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] cl_char(input logic [4:0] p);
    logic [14*8-1:0] s;
    s = "content-length";
    cl_char = (p < 5'd14) ? s[111 - 8*p -: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] ch_char(input logic [2:0] p);
    logic [7*8-1:0] s;
    s = "chunked";
    ch_char = (p < 3'd7) ? s[55 - 8*p -: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage

>>> src/http_request_stream_parser.sv
// Each result is registered and appears the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the output stalls; state is one register stage.
// The output register holds a result until it is taken while the next byte is accepted.
// Reset clears the parse state to the start of a method and the header limit to 64.
// ----------------------------------------------------------------------------
// HTTP request stream parser
// Byte-wide HTTP/1.x request parser with header spans and body de-framing.
// ----------------------------------------------------------------------------
module http_request_stream_parser #(
  parameter int unsigned MAX_HEADERS = hrsp_pkg::MaxHeaders,
  parameter int unsigned OFFSET_BITS = hrsp_pkg::OffsetBits,
  parameter int unsigned LENGTH_BITS = hrsp_pkg::LengthBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        new_request_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_res_o,
  output logic [3:0]  method_code_o,
  output logic        version_minor_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] first_start_o,
  output logic [15:0] first_length_o,
  output logic [15:0] second_start_o,
  output logic [15:0] second_length_o,
  output logic [5:0]  header_index_o,
  output logic [1:0]  body_kind_o,
  output logic [31:0] content_length_o,
  output logic [7:0]  body_data_o
);
  localparam logic [OFFSET_BITS-1:0] OffMax = '1;
  localparam logic [LENGTH_BITS-1:0] LenMax = '1;
  localparam int unsigned HsBits = $clog2(MAX_HEADERS + 1);

  typedef enum logic [17:0] {
    PH_METHOD = 18'd1 << 0, PH_URI = 18'd1 << 1, PH_VERSION = 18'd1 << 2,
    PH_LINE_START = 18'd1 << 3, PH_LINE_CR = 18'd1 << 4, PH_NAME = 18'd1 << 5,
    PH_VALUE_LEAD = 18'd1 << 6, PH_VALUE = 18'd1 << 7, PH_BODY_STREAM = 18'd1 << 8,
    PH_BODY_LENGTH = 18'd1 << 9, PH_CHUNK_SIZE = 18'd1 << 10, PH_CHUNK_DATA = 18'd1 << 11,
    PH_CHUNK_CR = 18'd1 << 12, PH_CHUNK_LF = 18'd1 << 13, PH_LAST_CR = 18'd1 << 14,
    PH_LAST_LF = 18'd1 << 15, PH_DONE = 18'd1 << 16, PH_ERROR = 18'd1 << 17
  } phase_e;

  logic [8:0] limit;

  hrsp_cfg #(.MAX_HEADERS(MAX_HEADERS)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .limit_o(limit)
  );

  // Parse state.
  phase_e                 phase_q, phase_d;
  logic [OFFSET_BITS-1:0] off_q, off_d, span_q, span_d, nend_q, nend_d;
  logic [OFFSET_BITS-1:0] vfirst_q, vfirst_d, vlast_q, vlast_d;
  logic [3:0]             kp_q, kp_d, meth_q, meth_d;
  logic                   ver_q, ver_d, dig_q, dig_d, cr_q, cr_d;
  logic [HsBits-1:0]      hs_q, hs_d;
  logic [6:0]             nmf_q, nmf_d;
  logic [4:0]             vmf_q, vmf_d;
  logic [1:0]             kind_q, kind_d;
  logic [LENGTH_BITS-1:0] acc_q, acc_d, left_q, left_d;

  // Result register.
  logic        ov_q;
  logic [3:0]  ev_q, ev_d, mc_q, mc_d;
  logic        vm_q, vm_d;
  logic [2:0]  ec_q, ec_d;
  logic [15:0] fs_q, fs_d, fl_q, fl_d, ss_q, ss_d, sl_q, sl_d;
  logic [5:0]  hi_q, hi_d;
  logic [1:0]  bk_q, bk_d;
  logic [31:0] cln_q, cln_d;
  logic [7:0]  bd_q, bd_d;

  logic accept;
  assign in_ready_o = !ov_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  function automatic logic [15:0] f16(input logic [OFFSET_BITS-1:0] v);
    if (OFFSET_BITS > 16 && (v >> 16) != '0) f16 = 16'hFFFF;
    else f16 = 16'(v);
  endfunction

  function automatic logic [31:0] f32(input logic [LENGTH_BITS-1:0] v);
    if (LENGTH_BITS > 32 && (v >> 32) != '0) f32 = 32'hFFFF_FFFF;
    else f32 = 32'(v);
  endfunction

  // acc*base + d with saturation; base is 10 or 16.
  function automatic logic [LENGTH_BITS-1:0] sat_mac(input logic [LENGTH_BITS-1:0] a,
                                                     input logic hex, input logic [3:0] d);
    logic [LENGTH_BITS+4:0] p;
    if (hex) p = {a, 4'b0} + (LENGTH_BITS+5)'(d);
    else p = {a, 3'b0} + {a, 1'b0} + (LENGTH_BITS+5)'(d);
    sat_mac = (p[LENGTH_BITS+4:LENGTH_BITS] != '0) ? LenMax : p[LENGTH_BITS-1:0];
  endfunction

  function automatic logic [6:0] name_cmp(input logic [6:0] f, input logic [7:0] b);
    logic [4:0] p;
    logic       te, cl;
    logic [7:0] lb;
    p  = f[6:2];
    te = f[0];
    cl = f[1];
    lb = hrsp_pkg::lower(b);
    if (p >= 5'd17 || lb != hrsp_pkg::te_char(p)) te = 1'b0;
    if (p >= 5'd14 || lb != hrsp_pkg::cl_char(p)) cl = 1'b0;
    if (p < 5'd31) p = p + 5'd1;
    name_cmp = {p, cl, te};
  endfunction

  function automatic logic [4:0] hexv(input logic [7:0] b);
    if (b >= "0" && b <= "9") hexv = {1'b1, 4'(b - "0")};
    else if (b >= "a" && b <= "f") hexv = {1'b1, 4'(b - "a" + 8'd10)};
    else if (b >= "A" && b <= "F") hexv = {1'b1, 4'(b - "A" + 8'd10)};
    else hexv = 5'd0;
  endfunction

  // Per-byte next-state and result logic.
  always_comb begin
    logic [7:0]             b, c, kc;
    logic [OFFSET_BITS-1:0] o, co;
    logic                   name_te, name_cl, live, gap, do_val, is_colon;
    logic [2:0]             vp;
    logic [4:0]             h;
    logic [3:0]             m, p;
    b = data_byte_i;
    phase_d = phase_q; off_d = off_q; span_d = span_q; nend_d = nend_q;
    vfirst_d = vfirst_q; vlast_d = vlast_q; kp_d = kp_q; meth_d = meth_q;
    ver_d = ver_q; dig_d = dig_q; cr_d = cr_q; hs_d = hs_q; nmf_d = nmf_q;
    vmf_d = vmf_q; kind_d = kind_q; acc_d = acc_q; left_d = left_q;
    c = 8'd0; co = '0; do_val = 1'b0; kc = 8'd0; m = 4'd0; p = 4'd0; h = 5'd0;
    live = 1'b0; gap = 1'b0; vp = 3'd0; is_colon = 1'b0;
    name_te = 1'b0; name_cl = 1'b0;
    ev_d = hrsp_pkg::EV_NONE; mc_d = 4'd0; vm_d = 1'b0; ec_d = hrsp_pkg::ERR_NONE;
    fs_d = 16'd0; fl_d = 16'd0; ss_d = 16'd0; sl_d = 16'd0; hi_d = 6'd0;
    bk_d = 2'd0; cln_d = 32'd0; bd_d = 8'd0;

    if (new_request_i) begin
      phase_d = PH_METHOD; off_d = '0; kp_d = 4'd0; meth_d = 4'd0; ver_d = 1'b1;
      hs_d = '0; span_d = '0; nend_d = '0; vfirst_d = '0; vlast_d = '0;
      nmf_d = 7'd3; vmf_d = 5'd1; kind_d = 2'd0; acc_d = '0; dig_d = 1'b1;
      left_d = '0; cr_d = 1'b0;
    end
    o = off_d;

    unique case (phase_d)
      PH_METHOD: begin
        if (kp_d == 4'd0) begin
          kp_d = 4'd1;
          unique case (b)
            "G": meth_d = 4'd0;
            "P": meth_d = 4'd1;
            "H": meth_d = 4'd4;
            "D": meth_d = 4'd5;
            "C": meth_d = 4'd6;
            "O": meth_d = 4'd7;
            "T": meth_d = 4'd8;
            default: begin
              kp_d = 4'd0; phase_d = PH_ERROR;
              ev_d = hrsp_pkg::EV_ERROR; ec_d = hrsp_pkg::ERR_METHOD;
            end
          endcase
        end else begin
          m = meth_d;
          p = kp_d;
          if (p == 4'd1 && m == 4'd1) begin
            if (b == "U") m = 4'd2;
            else if (b == "A") m = 4'd3;
          end
          meth_d = m;
          kc = hrsp_pkg::kw_char(m, p);
          if (m > 4'd8 || p >= hrsp_pkg::kw_len(m) || b != kc) begin
            phase_d = PH_ERROR; ev_d = hrsp_pkg::EV_ERROR; ec_d = hrsp_pkg::ERR_METHOD;
          end else begin
            p = p + 4'd1;
            if (p == hrsp_pkg::kw_len(m)) begin
              ev_d = hrsp_pkg::EV_METHOD; mc_d = m; phase_d = PH_URI;
              span_d = (o < OffMax) ? o + 1'b1 : OffMax;
            end
            kp_d = p;
          end
        end
      end
      PH_URI: begin
        if (b == " ") begin
          ev_d = hrsp_pkg::EV_URI; fs_d = f16(span_d); fl_d = f16(o - span_d);
          phase_d = PH_VERSION; kp_d = 4'd0;
        end
      end
      PH_VERSION: begin
        p = kp_d;
        kp_d = p + 4'd1;
        if (p < 4'd7) begin
          kc = (p == 4'd0) ? "H" : (p == 4'd1 || p == 4'd2) ? "T" : (p == 4'd3) ? "P" :
               (p == 4'd4) ? "/" : (p == 4'd5) ? "1" : ".";
          if (b != kc) begin
            phase_d = PH_ERROR; ev_d = hrsp_pkg::EV_ERROR; kp_d = p;
            ec_d = (p == 4'd5) ? hrsp_pkg::ERR_VER_UNKNOWN : hrsp_pkg::ERR_VER_MALFORM;
          end
        end else if (p == 4'd7) begin
          if (b != "0" && b != "1") begin
            phase_d = PH_ERROR; ev_d = hrsp_pkg::EV_ERROR; kp_d = p;
            ec_d = hrsp_pkg::ERR_VER_UNKNOWN;
          end else begin
            ver_d = b[0];
          end
        end else if (p == 4'd8) begin
          if (b != 8'h0D) begin
            phase_d = PH_ERROR; ev_d = hrsp_pkg::EV_ERROR; kp_d = p;
            ec_d = hrsp_pkg::ERR_VER_MALFORM;
          end
        end else begin
          kp_d = p;
          if (b != 8'h0A) begin
            phase_d = PH_ERROR; ev_d = hrsp_pkg::EV_ERROR; ec_d = hrsp_pkg::ERR_VER_MALFORM;
          end else begin
            ev_d = hrsp_pkg::EV_VERSION; vm_d = ver_d; phase_d = PH_LINE_START;
          end
        end
      end
      PH_LINE_START: begin
        if (b == 8'h0D) begin
          phase_d = PH_LINE_CR;
        end else begin
          span_d = o; nmf_d = name_cmp(7'd3, b); phase_d = PH_NAME;
        end
      end
      PH_LINE_CR: begin
        if (b == 8'h0A) begin
          // End of the header block.
          if (hs_d == '0) begin
            kind_d = 2'd0; ev_d = hrsp_pkg::EV_COMPLETE; phase_d = PH_DONE;
          end else if (kind_d == hrsp_pkg::KIND_LENGTH) begin
            if (acc_d == '0) begin
              ev_d = hrsp_pkg::EV_COMPLETE; phase_d = PH_DONE;
            end else begin
              left_d = acc_d; phase_d = PH_BODY_LENGTH; ev_d = hrsp_pkg::EV_HDR_END;
            end
          end else if (kind_d == hrsp_pkg::KIND_CHUNKED) begin
            acc_d = '0; phase_d = PH_CHUNK_SIZE; dig_d = 1'b1; kp_d = 4'd0;
            left_d = '0; cr_d = 1'b0; ev_d = hrsp_pkg::EV_HDR_END;
          end else begin
            acc_d = '0; phase_d = PH_BODY_STREAM; ev_d = hrsp_pkg::EV_HDR_END;
          end
          bk_d = kind_d; cln_d = f32(acc_d);
        end else begin
          span_d = o - 1'b1; nmf_d = name_cmp(7'd3, 8'h0D); phase_d = PH_NAME;
          is_colon = 1'b1;
        end
      end
      PH_NAME: is_colon = 1'b1;
      PH_VALUE_LEAD, PH_VALUE: begin
        if (cr_d && b == 8'h0A) begin
          // Header line end.
          if (9'(hs_d) >= limit) begin
            phase_d = PH_ERROR; ev_d = hrsp_pkg::EV_ERROR; ec_d = hrsp_pkg::ERR_HEADERS;
          end else begin
            ev_d = hrsp_pkg::EV_HEADER; fs_d = f16(span_d); fl_d = f16(nend_d - span_d);
            if (phase_d == PH_VALUE) begin
              ss_d = f16(vfirst_d); sl_d = f16(vlast_d - vfirst_d + 1'b1);
            end else begin
              ss_d = f16(o - 1'b1);
            end
            hi_d = 6'(hs_d);
            name_te = nmf_d[0] && nmf_d[6:2] == 5'd17;
            name_cl = nmf_d[1] && nmf_d[6:2] == 5'd14;
            if (kind_d == 2'd0) begin
              if (name_te && vmf_d[0] && vmf_d[3:1] == 3'd7) kind_d = hrsp_pkg::KIND_CHUNKED;
              else if (name_cl && phase_d == PH_VALUE) kind_d = hrsp_pkg::KIND_LENGTH;
            end
            hs_d = hs_d + 1'b1;
            phase_d = PH_LINE_START;
          end
        end else begin
          // A held CR is value content; then the current byte.
          if (cr_d) begin
            c = 8'h0D; co = o - 1'b1; do_val = 1'b1; cr_d = 1'b0;
          end else if (b != 8'h0D && b != " " && b != 8'h09) begin
            c = b; co = o; do_val = 1'b1;
          end
        end
      end
      PH_BODY_STREAM: begin
        acc_d = (acc_d < LenMax) ? acc_d + 1'b1 : LenMax;
        ev_d = hrsp_pkg::EV_BODY; bk_d = kind_d; cln_d = f32(acc_d); bd_d = b;
      end
      PH_BODY_LENGTH: begin
        left_d = left_d - 1'b1;
        if (left_d == '0) begin
          ev_d = hrsp_pkg::EV_COMPLETE; phase_d = PH_DONE;
        end else begin
          ev_d = hrsp_pkg::EV_BODY;
        end
        bk_d = kind_d; cln_d = f32(acc_d); bd_d = b;
      end
      PH_CHUNK_SIZE: begin
        if (cr_d && b == 8'h0A) begin
          cr_d = 1'b0;
          if (kp_d == 4'd0) begin
            phase_d = PH_ERROR; ev_d = hrsp_pkg::EV_ERROR; ec_d = hrsp_pkg::ERR_CHUNK;
          end else if (left_d == '0) begin
            phase_d = PH_LAST_CR;
          end else begin
            phase_d = PH_CHUNK_DATA;
          end
        end else begin
          cr_d = (b == 8'h0D);
          h = hexv(b);
          if (dig_d && h[4]) begin
            left_d = sat_mac(left_d, 1'b1, h[3:0]); kp_d = 4'd1;
          end else begin
            dig_d = 1'b0;
          end
        end
      end
      PH_CHUNK_DATA: begin
        acc_d = (acc_d < LenMax) ? acc_d + 1'b1 : LenMax;
        left_d = left_d - 1'b1;
        ev_d = hrsp_pkg::EV_BODY; bk_d = kind_d; cln_d = f32(acc_d); bd_d = b;
        if (left_d == '0) phase_d = PH_CHUNK_CR;
      end
      PH_CHUNK_CR: begin
        if (b == 8'h0D) phase_d = PH_CHUNK_LF;
        else begin
          phase_d = PH_ERROR; ev_d = hrsp_pkg::EV_ERROR; ec_d = hrsp_pkg::ERR_CHUNK;
        end
      end
      PH_CHUNK_LF: begin
        if (b == 8'h0A) begin
          phase_d = PH_CHUNK_SIZE; dig_d = 1'b1; kp_d = 4'd0; left_d = '0; cr_d = 1'b0;
        end else begin
          phase_d = PH_ERROR; ev_d = hrsp_pkg::EV_ERROR; ec_d = hrsp_pkg::ERR_CHUNK;
        end
      end
      PH_LAST_CR: begin
        if (b == 8'h0D) phase_d = PH_LAST_LF;
        else begin
          phase_d = PH_ERROR; ev_d = hrsp_pkg::EV_ERROR; ec_d = hrsp_pkg::ERR_CHUNK;
        end
      end
      PH_LAST_LF: begin
        if (b == 8'h0A) begin
          ev_d = hrsp_pkg::EV_COMPLETE; phase_d = PH_DONE; bk_d = kind_d; cln_d = f32(acc_d);
        end else begin
          phase_d = PH_ERROR; ev_d = hrsp_pkg::EV_ERROR; ec_d = hrsp_pkg::ERR_CHUNK;
        end
      end
      PH_DONE, PH_ERROR: ;
      default: ;
    endcase

    // Name byte: colon ends the name, anything else extends the compare.
    if (is_colon) begin
      if (b == ":") begin
        name_cl = nmf_d[1] && nmf_d[6:2] == 5'd14;
        nend_d = o; vmf_d = 5'd1; cr_d = 1'b0;
        dig_d = name_cl && kind_d == 2'd0;
        phase_d = PH_VALUE_LEAD;
      end else begin
        nmf_d = name_cmp(nmf_d, b);
      end
    end

    // Value content byte (the held CR or the current byte), then a new CR is held.
    if (do_val) begin
      live = vmf_d[0];
      vp = vmf_d[3:1];
      gap = (phase_d == PH_VALUE) && vmf_d[4];
      if (gap) live = 1'b0;
      if (vp >= 3'd7 || hrsp_pkg::lower(c) != hrsp_pkg::ch_char(vp)) live = 1'b0;
      else vp = vp + 3'd1;
      vmf_d = {1'b0, vp, live};
      if (dig_d) begin
        if (gap || c < "0" || c > "9") dig_d = 1'b0;
        else acc_d = sat_mac(acc_d, 1'b0, 4'(c - "0"));
      end
      if (phase_d == PH_VALUE_LEAD) begin
        vfirst_d = co; phase_d = PH_VALUE;
      end
      vlast_d = co;
      // Current byte after a held CR.
      if (c == 8'h0D && co != o) begin
        if (b == 8'h0D) cr_d = 1'b1;
        else if (b == " " || b == 8'h09) vmf_d[4] = 1'b1;
        else begin
          live = vmf_d[0];
          vp = vmf_d[3:1];
          gap = vmf_d[4];
          if (gap) live = 1'b0;
          if (vp >= 3'd7 || hrsp_pkg::lower(b) != hrsp_pkg::ch_char(vp)) live = 1'b0;
          else vp = vp + 3'd1;
          vmf_d = {1'b0, vp, live};
          if (dig_d) begin
            if (gap || b < "0" || b > "9") dig_d = 1'b0;
            else acc_d = sat_mac(acc_d, 1'b0, 4'(b - "0"));
          end
          vlast_d = o;
        end
      end
    end else if ((phase_q == PH_VALUE_LEAD || phase_q == PH_VALUE || new_request_i)
                 && (phase_d == PH_VALUE_LEAD || phase_d == PH_VALUE) && !is_colon) begin
      if (b == 8'h0D) cr_d = 1'b1;
      else if ((b == " " || b == 8'h09) && phase_d == PH_VALUE) vmf_d[4] = 1'b1;
    end

    off_d = (o < OffMax) ? o + 1'b1 : OffMax;
  end

  // State registers advance on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD; off_q <= '0; span_q <= '0; nend_q <= '0;
      vfirst_q <= '0; vlast_q <= '0; kp_q <= 4'd0; meth_q <= 4'd0; ver_q <= 1'b1;
      dig_q <= 1'b1; cr_q <= 1'b0; hs_q <= '0; nmf_q <= 7'd3; vmf_q <= 5'd1;
      kind_q <= 2'd0; acc_q <= '0; left_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d; off_q <= off_d; span_q <= span_d; nend_q <= nend_d;
      vfirst_q <= vfirst_d; vlast_q <= vlast_d; kp_q <= kp_d; meth_q <= meth_d;
      ver_q <= ver_d; dig_q <= dig_d; cr_q <= cr_d; hs_q <= hs_d; nmf_q <= nmf_d;
      vmf_q <= vmf_d; kind_q <= kind_d; acc_q <= acc_d; left_q <= left_d;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (accept) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q <= ev_d; mc_q <= mc_d; vm_q <= vm_d; ec_q <= ec_d; fs_q <= fs_d; fl_q <= fl_d;
      ss_q <= ss_d; sl_q <= sl_d; hi_q <= hi_d; bk_q <= bk_d; cln_q <= cln_d; bd_q <= bd_d;
    end
  end

  assign out_valid_o      = ov_q;
  assign event_res_o      = ev_q;
  assign method_code_o    = mc_q;
  assign version_minor_o  = vm_q;
  assign error_code_o     = ec_q;
  assign first_start_o    = fs_q;
  assign first_length_o   = fl_q;
  assign second_start_o   = ss_q;
  assign second_length_o  = sl_q;
  assign header_index_o   = hi_q;
  assign body_kind_o      = bk_q;
  assign content_length_o = cln_q;
  assign body_data_o      = bd_q;
endmodule

>>> src/hrsp_cfg.sv
// ----------------------------------------------------------------------------
// HTTP request parser configuration port
// APB-style register file holding the header limit, clamped for use.
// ----------------------------------------------------------------------------
module hrsp_cfg #(
  parameter int unsigned MAX_HEADERS = hrsp_pkg::MaxHeaders
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [8:0]  limit_o
);
  logic [6:0] limit_q;

  // Register write at the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 7'd64;
    end else if (psel && penable && pwrite && paddr == hrsp_pkg::RegHeaderLimit) begin
      limit_q <= pwdata[6:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == hrsp_pkg::RegHeaderLimit) ? {25'd0, limit_q} : 32'd0;

  // Clamp to 1..MAX_HEADERS.
  always_comb begin
    if (limit_q == 7'd0) limit_o = 9'd1;
    else if ({2'b0, limit_q} > 9'(MAX_HEADERS)) limit_o = 9'(MAX_HEADERS);
    else limit_o = {2'b0, limit_q};
  end
endmodule

>>> verif/hrsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request parser checker
// Watches the byte and result channels and the register port, predicts the
// result of every accepted byte and compares it with what the parser returns.
// ----------------------------------------------------------------------------
module hrsp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        new_request_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [3:0]  event_res_o,
  input  logic [3:0]  method_code_o,
  input  logic        version_minor_o,
  input  logic [2:0]  error_code_o,
  input  logic [15:0] first_start_o,
  input  logic [15:0] first_length_o,
  input  logic [15:0] second_start_o,
  input  logic [15:0] second_length_o,
  input  logic [5:0]  header_index_o,
  input  logic [1:0]  body_kind_o,
  input  logic [31:0] content_length_o,
  input  logic [7:0]  body_data_o,
  output int          fail_count,
  output int          words_pending
);

  localparam longint unsigned OffMax = 64'hFFFF;
  localparam longint unsigned LenMax = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [3:0]  ev;
    logic [3:0]  meth;
    logic        ver;
    logic [2:0]  err;
    logic [15:0] fs;
    logic [15:0] fl;
    logic [15:0] ss;
    logic [15:0] sl;
    logic [5:0]  hi;
    logic [1:0]  kind;
    logic [31:0] clen;
    logic [7:0]  body;
  } parse_word_t;

  typedef enum int {
    PH_METHOD, PH_URI, PH_VERSION, PH_LINE_START, PH_LINE_CR, PH_NAME, PH_VALUE_LEAD,
    PH_VALUE, PH_BODY_STREAM, PH_BODY_LENGTH, PH_CHUNK_SIZE, PH_CHUNK_DATA, PH_CHUNK_CR,
    PH_CHUNK_LF, PH_LAST_CR, PH_LAST_LF, PH_DONE, PH_ERROR
  } parse_phase_e;

  string method_word [9] = '{"GET ", "POST ", "PUT ", "PATCH ", "HEAD ", "DELETE ",
                             "CONNECT ", "OPTIONS ", "TRACE "};
  string te_word      = "transfer-encoding";
  string cl_word      = "content-length";
  string chunked_word = "chunked";
  string version_word = "HTTP/1.";

  parse_phase_e    phase;
  longint unsigned offset, span_start, colon_at, value_first, value_last;
  longint unsigned accum, chunk_left;
  int unsigned     progress, method_held, version_held, headers_seen, limit_reg;
  int unsigned     name_flags, value_flags, kind_held, digits_live, saw_cr;
  parse_word_t     word;
  parse_word_t     expected_words [$];

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic longint unsigned inc_sat(longint unsigned v, longint unsigned m);
    return (v < m) ? v + 1 : m;
  endfunction

  function automatic longint unsigned mac_sat(longint unsigned a, longint unsigned base,
                                              longint unsigned d);
    if (a > (LenMax - d) / base) return LenMax;
    return a * base + d;
  endfunction

  function automatic logic [15:0] clip16(longint unsigned v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic void clear_parse();
    phase = PH_METHOD; offset = 0; progress = 0; method_held = 0; version_held = 1;
    headers_seen = 0; span_start = 0; colon_at = 0; value_first = 0; value_last = 0;
    name_flags = 3; value_flags = 1; kind_held = 0; accum = 0; digits_live = 1;
    chunk_left = 0; saw_cr = 0;
  endfunction

  function automatic void raise_error(hrsp_pkg::error_e code);
    phase = PH_ERROR; word.ev = hrsp_pkg::EV_ERROR; word.err = code;
  endfunction

  function automatic void body_word(hrsp_pkg::event_e ev);
    word.ev = ev; word.kind = kind_held[1:0];
    word.clen = (accum > LenMax) ? 32'hFFFF_FFFF : accum[31:0];
  endfunction

  function automatic void open_chunk_line();
    phase = PH_CHUNK_SIZE; digits_live = 1; progress = 0; chunk_left = 0; saw_cr = 0;
  endfunction

  // Track the two interesting header names, case-insensitively.
  function automatic void match_name(logic [7:0] b);
    int unsigned p, te, cl;
    logic [7:0] lb;
    p = name_flags >> 2; te = name_flags & 1; cl = (name_flags >> 1) & 1; lb = to_lower(b);
    if (p >= 17 || lb != te_word[p]) te = 0;
    if (p >= 14 || lb != cl_word[p]) cl = 0;
    if (p < 31) p++;
    name_flags = te | (cl << 1) | (p << 2);
  endfunction

  function automatic bit name_is_te();
    return (name_flags & 1) && (name_flags >> 2) == 17;
  endfunction

  function automatic bit name_is_cl();
    return ((name_flags >> 1) & 1) && (name_flags >> 2) == 14;
  endfunction

  function automatic void name_char(logic [7:0] b, longint unsigned off);
    if (b == ":") begin
      colon_at = off; value_flags = 1; saw_cr = 0;
      digits_live = (name_is_cl() && kind_held == 0) ? 1 : 0;
      phase = PH_VALUE_LEAD;
    end else begin
      match_name(b);
    end
  endfunction

  // One non-blank value byte: chunked match, decimal length and span ends.
  function automatic void value_char(logic [7:0] c, longint unsigned o);
    int unsigned live, p;
    bit gap;
    live = value_flags & 1; p = (value_flags >> 1) & 7;
    gap = (phase == PH_VALUE) && ((value_flags & 16) != 0);
    if (gap) live = 0;
    if (p >= 7 || to_lower(c) != chunked_word[p]) live = 0;
    else p++;
    value_flags = live | (p << 1);
    if (digits_live != 0) begin
      if (gap || c < "0" || c > "9") digits_live = 0;
      else accum = mac_sat(accum, 10, c - "0");
    end
    if (phase == PH_VALUE_LEAD) begin
      value_first = o; phase = PH_VALUE;
    end
    value_last = o;
  endfunction

  function automatic void close_header(longint unsigned off);
    int unsigned lim;
    lim = limit_reg;
    if (lim < 1) lim = 1;
    if (lim > 64) lim = 64;
    if (headers_seen >= lim) begin
      raise_error(hrsp_pkg::ERR_HEADERS);
      return;
    end
    word.ev = hrsp_pkg::EV_HEADER;
    word.fs = clip16(span_start);
    word.fl = clip16(colon_at - span_start);
    if (phase == PH_VALUE) begin
      word.ss = clip16(value_first);
      word.sl = clip16(value_last - value_first + 1);
    end else begin
      word.ss = clip16(off - 1);
    end
    word.hi = headers_seen[5:0];
    if (kind_held == 0) begin
      if (name_is_te() && (value_flags & 1) && ((value_flags >> 1) & 7) == 7) kind_held = 2;
      else if (name_is_cl() && phase == PH_VALUE) kind_held = 1;
    end
    headers_seen++;
    phase = PH_LINE_START;
  endfunction

  function automatic void close_headers();
    if (headers_seen == 0) begin
      kind_held = 0; body_word(hrsp_pkg::EV_COMPLETE); phase = PH_DONE;
      return;
    end
    if (kind_held == 1) begin
      if (accum == 0) begin
        body_word(hrsp_pkg::EV_COMPLETE); phase = PH_DONE;
        return;
      end
      chunk_left = accum; phase = PH_BODY_LENGTH;
    end else if (kind_held == 2) begin
      accum = 0; open_chunk_line();
    end else begin
      accum = 0; phase = PH_BODY_STREAM;
    end
    body_word(hrsp_pkg::EV_HDR_END);
  endfunction

  function automatic void method_char(logic [7:0] b);
    int unsigned p;
    p = progress;
    if (p == 0) begin
      case (b)
        "G": method_held = 0;
        "P": method_held = 1;
        "H": method_held = 4;
        "D": method_held = 5;
        "C": method_held = 6;
        "O": method_held = 7;
        "T": method_held = 8;
        default: begin
          raise_error(hrsp_pkg::ERR_METHOD);
          return;
        end
      endcase
      progress = 1;
      return;
    end
    // The P methods split on their second letter.
    if (p == 1 && method_held == 1) begin
      if (b == "U") method_held = 2;
      else if (b == "A") method_held = 3;
    end
    if (p >= method_word[method_held].len() || b != method_word[method_held][p]) begin
      raise_error(hrsp_pkg::ERR_METHOD);
      return;
    end
    p++;
    if (p == method_word[method_held].len()) begin
      word.ev = hrsp_pkg::EV_METHOD; word.meth = method_held[3:0];
      phase = PH_URI; span_start = inc_sat(offset, OffMax);
    end
    progress = p & 15;
  endfunction

  function automatic void version_char(logic [7:0] b);
    int unsigned p;
    p = progress;
    if (p < 7) begin
      if (b != version_word[p]) begin
        raise_error(p == 5 ? hrsp_pkg::ERR_VER_UNKNOWN : hrsp_pkg::ERR_VER_MALFORM);
        return;
      end
    end else if (p == 7) begin
      if (b != "0" && b != "1") begin
        raise_error(hrsp_pkg::ERR_VER_UNKNOWN);
        return;
      end
      version_held = b - "0";
    end else if (p == 8) begin
      if (b != "\r") begin
        raise_error(hrsp_pkg::ERR_VER_MALFORM);
        return;
      end
    end else begin
      if (b != "\n") begin
        raise_error(hrsp_pkg::ERR_VER_MALFORM);
        return;
      end
      word.ev = hrsp_pkg::EV_VERSION; word.ver = version_held[0];
      phase = PH_LINE_START;
      return;
    end
    progress = p + 1;
  endfunction

  function automatic int hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  // Advance the parse by one byte and leave the expected word in word.
  function automatic void parse_byte(logic [7:0] b, logic nr);
    longint unsigned off;
    int h;
    if (nr) clear_parse();
    off = offset;
    word = '0;
    case (phase)
      PH_METHOD: method_char(b);
      PH_URI: begin
        if (b == " ") begin
          word.ev = hrsp_pkg::EV_URI; word.fs = clip16(span_start);
          word.fl = clip16(off - span_start);
          phase = PH_VERSION; progress = 0;
        end
      end
      PH_VERSION: version_char(b);
      PH_LINE_START: begin
        if (b == "\r") phase = PH_LINE_CR;
        else begin
          span_start = off; name_flags = 3; match_name(b); phase = PH_NAME;
        end
      end
      PH_LINE_CR: begin
        if (b == "\n") close_headers();
        else begin
          span_start = off - 1; name_flags = 3; match_name("\r"); phase = PH_NAME;
          name_char(b, off);
        end
      end
      PH_NAME: name_char(b, off);
      PH_VALUE_LEAD, PH_VALUE: begin
        if (saw_cr != 0 && b == "\n") close_header(off);
        else begin
          if (saw_cr != 0) begin
            value_char("\r", off - 1); saw_cr = 0;
          end
          if (b == "\r") saw_cr = 1;
          else if (b == " " || b == "\t") begin
            if (phase == PH_VALUE) value_flags |= 16;
          end else value_char(b, off);
        end
      end
      PH_BODY_STREAM: begin
        accum = inc_sat(accum, LenMax);
        body_word(hrsp_pkg::EV_BODY); word.body = b;
      end
      PH_BODY_LENGTH: begin
        chunk_left--;
        if (chunk_left == 0) begin
          body_word(hrsp_pkg::EV_COMPLETE); phase = PH_DONE;
        end else body_word(hrsp_pkg::EV_BODY);
        word.body = b;
      end
      PH_CHUNK_SIZE: begin
        if (saw_cr != 0 && b == "\n") begin
          saw_cr = 0;
          if (progress == 0) raise_error(hrsp_pkg::ERR_CHUNK);
          else if (chunk_left == 0) phase = PH_LAST_CR;
          else phase = PH_CHUNK_DATA;
        end else begin
          saw_cr = (b == "\r");
          h = hex_digit(b);
          if (digits_live != 0 && h >= 0) begin
            chunk_left = mac_sat(chunk_left, 16, h); progress = 1;
          end else digits_live = 0;
        end
      end
      PH_CHUNK_DATA: begin
        accum = inc_sat(accum, LenMax);
        chunk_left--;
        body_word(hrsp_pkg::EV_BODY); word.body = b;
        if (chunk_left == 0) phase = PH_CHUNK_CR;
      end
      PH_CHUNK_CR: if (b == "\r") phase = PH_CHUNK_LF; else raise_error(hrsp_pkg::ERR_CHUNK);
      PH_CHUNK_LF: if (b == "\n") open_chunk_line(); else raise_error(hrsp_pkg::ERR_CHUNK);
      PH_LAST_CR: if (b == "\r") phase = PH_LAST_LF; else raise_error(hrsp_pkg::ERR_CHUNK);
      PH_LAST_LF: begin
        if (b == "\n") begin
          body_word(hrsp_pkg::EV_COMPLETE); phase = PH_DONE;
        end else raise_error(hrsp_pkg::ERR_CHUNK);
      end
      default: ;
    endcase
    offset = inc_sat(off, OffMax);
  endfunction

  // Compare each returned word with the oldest prediction, then predict new bytes.
  always @(posedge clk_i or negedge rst_ni) begin
    parse_word_t got, want;
    if (!rst_ni) begin
      clear_parse();
      limit_reg = 64;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{event_res_o, method_code_o, version_minor_o, error_code_o, first_start_o,
                first_length_o, second_start_o, second_length_o, header_index_o,
                body_kind_o, content_length_o, body_data_o};
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: unexpected result word %h", $realtime, got);
        end else begin
          want = expected_words.pop_front();
          if (got.ev !== want.ev || got.meth !== want.meth || got.ver !== want.ver ||
              got.err !== want.err || got.fs !== want.fs || got.fl !== want.fl ||
              got.ss !== want.ss || got.sl !== want.sl || got.hi !== want.hi ||
              got.kind !== want.kind || got.clen !== want.clen || got.body !== want.body) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch ev/meth/ver/err exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       $realtime, want.ev, want.meth, want.ver, want.err,
                       got.ev, got.meth, got.ver, got.err);
              $display("  spans exp %0d,%0d %0d,%0d got %0d,%0d %0d,%0d", want.fs, want.fl,
                       want.ss, want.sl, got.fs, got.fl, got.ss, got.sl);
              $display("  hi/kind/len/data exp %0d/%0d/%0d/%h got %0d/%0d/%0d/%h",
                       want.hi, want.kind, want.clen, want.body,
                       got.hi, got.kind, got.clen, got.body);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        parse_byte(data_byte_i, new_request_i);
        expected_words.push_back(word);
      end
      if (psel && penable && pwrite && pready && paddr == hrsp_pkg::RegHeaderLimit)
        limit_reg = pwdata[6:0];
    end
    words_pending = expected_words.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request parser testbench
// Feeds directed and random request streams, some well formed and some broken,
// under random idling on both channels and several header limits.
// ----------------------------------------------------------------------------
module tb;

  localparam int RandomBytes = 700;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [0:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid_i, in_ready_o, new_request_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o, out_ready_i;
  logic [3:0]  event_res_o, method_code_o;
  logic        version_minor_o;
  logic [2:0]  error_code_o;
  logic [15:0] first_start_o, first_length_o, second_start_o, second_length_o;
  logic [5:0]  header_index_o;
  logic [1:0]  body_kind_o;
  logic [31:0] content_length_o;
  logic [7:0]  body_data_o;
  int          fail_count, words_pending;

  bit          quiet;
  bit          hold_request;
  int          bytes_sent;
  int          requests_sent;
  logic [7:0]  request_bytes [$];

  string method_text [9] = '{"GET ", "POST ", "PUT ", "PATCH ", "HEAD ", "DELETE ",
                             "CONNECT ", "OPTIONS ", "TRACE "};
  string plain_names [5] = '{"Host", "Accept", "X-Id", "content-lengthy", "Transfer"};

  http_request_stream_parser dut (.*);

  hrsp_checker u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver side: random stalls, one long hold-off, always ready near the end.
  initial begin
    int n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        for (n = 0; n < 200; n++) @(posedge clk_i);
      end else if (quiet || $urandom_range(0, 5) != 0) begin
        out_ready_i <= 1'b1;
        n = quiet ? 1 : $urandom_range(1, 20);
        repeat (n) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  task automatic send_word(logic [7:0] b, logic first);
    bit rdy;
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    new_request_i <= first;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    bytes_sent++;
  endtask

  task automatic send_request();
    foreach (request_bytes[i]) send_word(request_bytes[i], i == 0);
    requests_sent++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
  endtask

  task automatic add_blanks();
    repeat ($urandom_range(0, 2)) add_text($urandom_range(0, 1) ? " " : "\t");
  endtask

  task automatic add_token(int lo, int hi);
    string pool;
    pool = "abcXYZ019/-=;.";
    repeat ($urandom_range(lo, hi)) request_bytes.push_back(pool[$urandom_range(0, 13)]);
  endtask

  // Only written while nothing is in flight.
  task automatic write_limit(logic [31:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= hrsp_pkg::RegHeaderLimit; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // A mostly well-formed request with random content and framing.
  task automatic build_random();
    int body_sel, n_hdr, body_pos, len, pick;
    request_bytes.delete();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 30)) request_bytes.push_back($urandom_range(0, 255));
      return;
    end
    pick = $urandom_range(0, 24);
    if (pick == 0) add_text("PX ");
    else if (pick == 1) add_text("GEt ");
    else if (pick == 2) request_bytes.push_back($urandom_range(0, 255));
    else add_text(method_text[$urandom_range(0, 8)]);
    if ($urandom_range(0, 9) != 0) begin
      add_text("/");
      add_token(0, 8);
    end
    add_text($urandom_range(0, 1) ? " HTTP/1.1\r\n" : " HTTP/1.0\r\n");
    if ($urandom_range(0, 14) == 0)
      request_bytes[request_bytes.size() - $urandom_range(1, 10)] = $urandom_range(0, 255);
    body_sel = $urandom_range(0, 2);
    n_hdr    = $urandom_range(0, 5) + (body_sel != 0);
    body_pos = $urandom_range(0, n_hdr - 1);
    len      = $urandom_range(0, 12);
    for (int i = 0; i < n_hdr; i++) begin
      if (i == body_pos && body_sel == 1) begin
        add_text($urandom_range(0, 1) ? "Content-Length:" : "content-LENGTH:");
        add_blanks(); add_text($sformatf("%0d", len)); add_blanks();
      end else if (i == body_pos && body_sel == 2) begin
        add_text($urandom_range(0, 1) ? "Transfer-Encoding:" : "TRANSFER-encoding:");
        add_blanks(); add_text($urandom_range(0, 1) ? "chunked" : "Chunked"); add_blanks();
      end else begin
        add_text(plain_names[$urandom_range(0, 4)]);
        if ($urandom_range(0, 9) == 0) add_text("\r\nmore");
        add_text(":");
        add_blanks(); add_token(0, 6);
        if ($urandom_range(0, 9) == 0) add_text("\rq");
        add_blanks();
      end
      add_text("\r\n");
    end
    add_text("\r\n");
    if (body_sel == 1) begin
      repeat (len + $urandom_range(0, 2)) request_bytes.push_back($urandom_range(0, 255));
    end else if (body_sel == 2) begin
      repeat ($urandom_range(0, 3)) begin
        len = $urandom_range(1, 20);
        add_text($sformatf("%0h", len));
        if ($urandom_range(0, 4) == 0) add_text(";ext");
        add_text("\r\n");
        repeat (len) request_bytes.push_back($urandom_range(0, 255));
        add_text("\r\n");
      end
      add_text("0\r\n\r\n");
      if ($urandom_range(0, 9) == 0)
        request_bytes[request_bytes.size() - $urandom_range(1, 8)] = $urandom_range(0, 255);
    end else begin
      repeat ($urandom_range(0, 8)) request_bytes.push_back($urandom_range(0, 255));
    end
  endtask

  task automatic run_text(string s);
    request_bytes.delete();
    add_text(s);
    send_request();
  endtask

  initial begin
    string directed [$];
    int    start_bytes;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; data_byte_i = '0; new_request_i = 1'b0;
    quiet = 1'b0; hold_request = 1'b0; bytes_sent = 0; requests_sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every method, non-limit errors and the framing corner cases.
    foreach (method_text[i]) directed.push_back({method_text[i], "/a HTTP/1.1\r\n\r\n"});
    directed.push_back("PX / HTTP/1.1\r\n");
    directed.push_back("\377\000");
    directed.push_back("PUT  HTTP/1.0\r\n:x\r\n\rA: b\r\nHost:\r\nName\r\nmore: a\rb\r\n\r\nzz");
    directed.push_back("GET / HTTX/1.1\r\n");
    directed.push_back("GET / HTTP/2.1\r\n");
    directed.push_back("GET / HTTP/1.5\r\n");
    directed.push_back("GET / HTTP/1.1\rX");
    directed.push_back("POST /u HTTP/1.1\r\ncontent-length: 0\r\n\r\n");
    directed.push_back("POST /u HTTP/1.1\r\nContent-Length:  3 \r\nContent-Length: 9\r\n\r\nabcQ");
    directed.push_back("POST / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\n3;x\r\nabc\r\n0\r\n\r\n");
    directed.push_back("POST / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\nz\r\n");
    directed.push_back("POST / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\n2\r\nabX");
    directed.push_back("POST / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\nFFFFFFFFFF\r\nab");
    directed.push_back("POST / HTTP/1.1\r\nContent-Length: 99999999999\r\n\r\nab");
    foreach (directed[i]) run_text(directed[i]);

    // Random part across several header limits, extremes included.
    start_bytes = bytes_sent;
    for (int phase_no = 0; phase_no < 5; phase_no++) begin
      case (phase_no)
        0: write_limit(32'd2);
        1: begin
          write_limit(32'd0);
          hold_request = 1'b1;
        end
        2: write_limit(32'd127);
        3: write_limit(32'd1);
        default: write_limit(32'd64);
      endcase
      while (bytes_sent - start_bytes < (phase_no + 1) * RandomBytes / 5) begin
        if (phase_no == 4 && bytes_sent - start_bytes > RandomBytes * 9 / 10) quiet = 1'b1;
        build_random();
        send_request();
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d requests (%0d bytes) over five header limits,", requests_sent,
             bytes_sent);
    $display("with random stalls on both channels and one long output hold-off.");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
